// ----- src/edr_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, link and control types for the edit distance row engine
package edr_pkg;

    localparam int MAX_REF_LEN = 64;
    localparam int COST_WIDTH  = 8;
    localparam int SYM_W       = 8;
    localparam int LEN_W       = $clog2(MAX_REF_LEN + 1);
    localparam int CNT_W       = $clog2(MAX_REF_LEN + 2);
    localparam int OUT_DATA_W  = ((COST_WIDTH + 7) / 8) * 8;

    localparam logic [COST_WIDTH-1:0] COST_MAX = '1;

    // command codes carried on s_tuser
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_END    = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // wavefront data handed from one cell to the next
    typedef struct packed {
        logic                  valid;
        logic                  sat;
        logic [SYM_W-1:0]      sym;
        logic [COST_WIDTH-1:0] cost_new;
        logic [COST_WIDTH-1:0] diag;
    } edr_link_t;

    // per-cell control from the top level
    typedef struct packed {
        logic                  restart;
        logic [COST_WIDTH-1:0] init_cost;
        logic                  in_range;
        logic                  ref_we;
        logic [SYM_W-1:0]      ref_sym;
    } edr_cell_ctrl_t;

    // cost value for a length, held at the cost limit
    function automatic logic [COST_WIDTH-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [COST_WIDTH-1:0] res;
        if (int'(len) >= int'(COST_MAX))
            res = COST_MAX;
        else
            res = COST_WIDTH'(len);
        return res;
    endfunction

endpackage

// ----- src/edr_cell.sv -----
`timescale 1ns / 1ps
// one row cell: holds a cost entry and a reference symbol, updates as the wavefront passes
module edr_cell
    import edr_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  edr_cell_ctrl_t ctrl,
    input  edr_link_t      link_in,
    output edr_link_t      link_out
);

    logic [COST_WIDTH-1:0] cost_reg;
    logic [COST_WIDTH-1:0] cost_next;
    logic [SYM_W-1:0]      ref_reg;
    edr_link_t             link_reg;
    edr_link_t             link_next;

    logic                  mismatch;
    logic                  hit_max;
    logic [COST_WIDTH:0]   cand_diag;
    logic [COST_WIDTH:0]   cand_above;
    logic [COST_WIDTH:0]   cand_left;
    logic [COST_WIDTH:0]   best;
    logic [COST_WIDTH-1:0] cost_calc;

    always_comb
    begin
        mismatch   = (link_in.sym != ref_reg);
        cand_diag  = {1'b0, link_in.diag} + (COST_WIDTH + 1)'(mismatch);
        cand_above = {1'b0, cost_reg} + (COST_WIDTH + 1)'(1);
        cand_left  = {1'b0, link_in.cost_new} + (COST_WIDTH + 1)'(1);
        best = cand_diag;
        if (cand_above < best)
            best = cand_above;
        if (cand_left < best)
            best = cand_left;
        hit_max   = (best >= {1'b0, COST_MAX});
        cost_calc = hit_max ? COST_MAX : best[COST_WIDTH-1:0];

        cost_next = cost_reg;
        if (ctrl.restart)
            cost_next = ctrl.init_cost;
        else if (link_in.valid && ctrl.in_range)
            cost_next = cost_calc;

        // past the reference end the cell just forwards the last live entry
        link_next      = link_in;
        link_next.diag = cost_reg;
        if (ctrl.in_range)
        begin
            link_next.cost_new = cost_calc;
            link_next.sat      = link_in.sat | hit_max;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            link_reg <= '0;
        else
            link_reg <= link_next;
    end

    always_ff @(posedge clk)
    begin
        cost_reg <= cost_next;
        if (ctrl.ref_we)
            ref_reg <= ctrl.ref_sym;
    end

    assign link_out = link_reg;

endmodule

// ----- src/edit_distance_row_engine_unit.sv -----
`timescale 1ns / 1ps
// levenshtein row engine: command decode, chain of row cells and result register
// a query symbol sweeps cells 0..MAX_REF_LEN, one per cycle
// throughput: one query symbol per cycle after the reset load, the wavefronts follow each other down the chain
// append, clear and end wait until the chain has drained
// the result is registered at the end transfer, offered in the next cycle and held until taken
// reset is asynchronous: length and flags clear, then a restart loads the row with 0..MAX_REF_LEN
module edit_distance_row_engine_unit
    import edr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SYM_W-1:0]      s_tdata,   // [7:0] symbol
    input  logic [1:0]            s_tuser,   // [1:0] command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] distance
    output logic [1:0]            m_tuser    // [0] saturated, [1] reference_dropped
);

    // state of the block outside the cells
    logic                  init_pending_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [LEN_W-1:0]      len_next;
    logic                  drop_reg;
    logic                  drop_next;
    logic                  sat_reg;
    logic                  sat_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [COST_WIDTH-1:0] last_cost_reg;
    logic [COST_WIDTH-1:0] last_cost_next;

    // result register, parts the output side from the input side
    logic                  out_valid_reg;
    logic [COST_WIDTH-1:0] out_dist_reg;
    logic                  out_sat_reg;
    logic                  out_drop_reg;

    logic                  in_xfer;
    logic                  query_xfer;
    logic                  end_xfer;
    logic                  restart;
    logic                  ready;

    edr_link_t             link [0:MAX_REF_LEN+1];
    edr_cell_ctrl_t        ctrl [0:MAX_REF_LEN];

    // a query may follow another at once; anything else needs a drained chain, and end also a free result register
    always_comb
    begin
        ready = 1'b0;
        if (!init_pending_reg)
        begin
            case (s_tuser)
                CMD_QUERY: ready = 1'b1;
                CMD_END:   ready = (cnt_reg == '0) && (!out_valid_reg || m_tready);
                default:   ready = (cnt_reg == '0);
            endcase
        end
    end

    assign s_tready   = ready;
    assign in_xfer    = s_tvalid && ready;
    assign query_xfer = in_xfer && (s_tuser == CMD_QUERY);
    assign end_xfer   = in_xfer && (s_tuser == CMD_END);
    // every command but a query symbol restarts the row
    assign restart    = init_pending_reg || (in_xfer && (s_tuser != CMD_QUERY));

    always_comb
    begin
        len_next  = len_reg;
        drop_next = drop_reg;
        if (in_xfer)
        begin
            case (s_tuser)
                CMD_APPEND:
                begin
                    if (int'(len_reg) < MAX_REF_LEN)
                        len_next = len_reg + LEN_W'(1);
                    else
                        drop_next = 1'b1;
                end
                CMD_CLEAR:
                begin
                    len_next  = '0;
                    drop_next = 1'b0;
                end
                default:
                begin
                    len_next  = len_reg;
                    drop_next = drop_reg;
                end
            endcase
        end

        // the chain end carries the entry at the reference length and the wavefront's sat
        if (restart)
        begin
            sat_next       = (int'(len_next) > int'(COST_MAX));
            last_cost_next = clamp_len(len_next);
        end
        else if (link[MAX_REF_LEN+1].valid)
        begin
            sat_next       = sat_reg | link[MAX_REF_LEN+1].sat;
            last_cost_next = link[MAX_REF_LEN+1].cost_new;
        end
        else
        begin
            sat_next       = sat_reg;
            last_cost_next = last_cost_reg;
        end

        // cycles until the newest wavefront has left the chain
        if (query_xfer)
            cnt_next = CNT_W'(MAX_REF_LEN + 1);
        else if (cnt_reg != '0)
            cnt_next = cnt_reg - CNT_W'(1);
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_pending_reg <= 1'b1;
            len_reg          <= '0;
            drop_reg         <= 1'b0;
            sat_reg          <= 1'b0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            init_pending_reg <= 1'b0;
            len_reg          <= len_next;
            drop_reg         <= drop_next;
            sat_reg          <= sat_next;
            cnt_reg          <= cnt_next;
            if (end_xfer)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        last_cost_reg <= last_cost_next;
        if (end_xfer)
        begin
            out_dist_reg <= last_cost_reg;
            out_sat_reg  <= sat_reg;
            out_drop_reg <= drop_reg;
        end
    end

    // left boundary: cell 0 sees the limit on both neighbors, so it just adds one
    assign link[0] = '{valid:    query_xfer,
                       sat:      1'b0,
                       sym:      s_tdata,
                       cost_new: COST_MAX,
                       diag:     COST_MAX};

    // cell j holds row entry j and reference symbol j-1
    for (genvar j = 0; j <= MAX_REF_LEN; j++)
    begin : g_cell
        if (j == 0)
        begin : g_first
            // no reference symbol here, a fixed one keeps the unused compare defined
            assign ctrl[j] = '{restart:   restart,
                               init_cost: clamp_len(LEN_W'(j)),
                               in_range:  1'b1,
                               ref_we:    restart,
                               ref_sym:   '0};
        end
        else
        begin : g_rest
            assign ctrl[j] = '{restart:   restart,
                               init_cost: clamp_len(LEN_W'(j)),
                               in_range:  (LEN_W'(j) <= len_reg),
                               ref_we:    in_xfer && (s_tuser == CMD_APPEND)
                                          && (len_reg == LEN_W'(j - 1)),
                               ref_sym:   s_tdata};
        end

        edr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl[j]),
            .link_in  (link[j]),
            .link_out (link[j+1])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_dist_reg);
    assign m_tuser  = {out_drop_reg, out_sat_reg};

endmodule

// ----- src/edr_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the edit distance row engine, bound to the top level
module edr_checker
    import edr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [1:0]            s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]            m_tuser
);

    logic in_xfer;
    logic query_xfer;
    logic end_xfer;

    assign in_xfer    = s_tvalid && s_tready;
    assign query_xfer = in_xfer && (s_tuser == CMD_QUERY);
    assign end_xfer   = in_xfer && (s_tuser == CMD_END);

    // a result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // every end transfer yields a result in the next cycle
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        end_xfer |=> m_tvalid)
        else $error("end transfer gave no result");

    // a result only appears after an end transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(end_xfer))
        else $error("result without end transfer");

    // a non-query command must not be taken straight after a query transfer, since the row has to drain
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        query_xfer |=> !(s_tvalid && s_tready && (s_tuser != CMD_QUERY)))
        else $error("command taken while wavefront in flight");

endmodule

bind edit_distance_row_engine_unit edr_checker u_edr_checker (.*);
